// ----- hw/rtl/sci_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package sci_pkg;
    localparam int SCI_COORD_WIDTH = 16;
endpackage
`default_nettype wire

// ----- hw/rtl/segment_circle_intersect.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Channel   Dir  Ports            Fields (low bit up)
// s_axis    in   tvalid/tready    tdata: start_x, start_y, end_x, end_y, centre_x, centre_y,
//                                 radius, zero pad
// m_axis    out  tvalid/tready    tdata: hit, intersect_x, intersect_y, zero pad
//
// One request per cycle while m_axis is not stalled; the pipeline depth is set by the
// digit-serial square root (one root bit per stage) and the restoring divider (one
// quotient bit per stage). Synchronous active-low reset clears the stage valid bits.
// A stalled output freezes the whole pipeline; nothing is lost or repeated.
module segment_circle_intersect #(
    parameter int COORD_WIDTH = sci_pkg::SCI_COORD_WIDTH
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  s_axis_tvalid,
    output logic s_axis_tready,
    // start_x, start_y, end_x, end_y, centre_x, centre_y, radius
    input  wire  [((7*COORD_WIDTH-1+7)/8)*8-1:0] s_axis_tdata,
    output logic m_axis_tvalid,
    input  wire  m_axis_tready,
    // hit, intersect_x, intersect_y
    output logic [((2*COORD_WIDTH+1+7)/8)*8-1:0] m_axis_tdata
);
    localparam int W      = COORD_WIDTH;
    localparam int DW     = W + 1;
    localparam int AW     = 2*W + 2;
    localparam int HB     = W + 1;
    localparam int HW     = 2*W + 3;
    localparam int MW     = 4*W + 4;
    localparam int SQ     = 2*W + 2;
    localparam int SW     = 2*W + 2;
    localparam int RW     = SW + 2;
    localparam int NW     = 2*W + 4;
    localparam int NMW    = 2*W + 3;
    localparam int NLB    = W + 2;
    localparam int NHB    = NMW - NLB;
    localparam int NUMW   = 3*W + 5;
    localparam int SUMW   = NUMW + 2;
    localparam int OUT_TW = ((2*W+1+7)/8)*8;
    localparam logic signed [W-1:0] C_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] C_MIN = {1'b1, {(W-1){1'b0}}};

    typedef struct packed {
        logic signed [W-1:0]  sx;
        logic signed [W-1:0]  sy;
        logic signed [DW-1:0] dx;
        logic signed [DW-1:0] dy;
        logic                 deg;
    } t_geo;

    typedef struct packed {
        t_geo          g;
        logic [AW-1:0] a;
        logic          z;
        logic          hit;
        logic          sgx;
        logic          sgy;
    } t_tail;

    logic w_en;
    assign w_en          = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_en;

    // stage 1: differences
    logic [W-1:0] w_sx, w_sy, w_ex, w_ey, w_cx, w_cy;
    logic [W-2:0] w_r;
    assign w_sx = s_axis_tdata[W-1:0];
    assign w_sy = s_axis_tdata[2*W-1:W];
    assign w_ex = s_axis_tdata[3*W-1:2*W];
    assign w_ey = s_axis_tdata[4*W-1:3*W];
    assign w_cx = s_axis_tdata[5*W-1:4*W];
    assign w_cy = s_axis_tdata[6*W-1:5*W];
    assign w_r  = s_axis_tdata[7*W-2:6*W];

    logic                 r_v1;
    t_geo                 r1_g;
    logic signed [DW-1:0] r1_fx, r1_fy;
    logic [W-2:0]         r1_r;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= s_axis_tvalid;
        end
        if (w_en) begin
            r1_g.sx  <= w_sx;
            r1_g.sy  <= w_sy;
            r1_g.dx  <= $signed({w_ex[W-1], w_ex}) - $signed({w_sx[W-1], w_sx});
            r1_g.dy  <= $signed({w_ey[W-1], w_ey}) - $signed({w_sy[W-1], w_sy});
            r1_g.deg <= (w_ex == w_sx) && (w_ey == w_sy);
            r1_fx    <= $signed({w_sx[W-1], w_sx}) - $signed({w_cx[W-1], w_cx});
            r1_fy    <= $signed({w_sy[W-1], w_sy}) - $signed({w_cy[W-1], w_cy});
            r1_r     <= w_r;
        end
    end

    // stage 2: products
    logic                   r_v2;
    t_geo                   r2_g;
    logic signed [2*DW-1:0] r2_xx, r2_yy, r2_xf, r2_yf, r2_fx, r2_fy;
    logic [2*W-3:0]         r2_rr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_en) begin
            r_v2 <= r_v1;
        end
        if (w_en) begin
            r2_g  <= r1_g;
            r2_xx <= (2*DW)'(r1_g.dx) * (2*DW)'(r1_g.dx);
            r2_yy <= (2*DW)'(r1_g.dy) * (2*DW)'(r1_g.dy);
            r2_xf <= (2*DW)'(r1_g.dx) * (2*DW)'(r1_fx);
            r2_yf <= (2*DW)'(r1_g.dy) * (2*DW)'(r1_fy);
            r2_fx <= (2*DW)'(r1_fx) * (2*DW)'(r1_fx);
            r2_fy <= (2*DW)'(r1_fy) * (2*DW)'(r1_fy);
            r2_rr <= (2*W-2)'(r1_r) * (2*W-2)'(r1_r);
        end
    end

    // stage 3: a, h, c
    logic                 r_v3;
    t_geo                 r3_g;
    logic [AW-1:0]        r3_a;
    logic signed [HW-1:0] r3_h, r3_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (w_en) begin
            r_v3 <= r_v2;
        end
        if (w_en) begin
            r3_g <= r2_g;
            r3_a <= AW'(r2_xx) + AW'(r2_yy);
            r3_h <= HW'(r2_xf) + HW'(r2_yf);
            r3_c <= HW'(r2_fx) + HW'(r2_fy) - $signed(HW'(r2_rr));
        end
    end

    // stage 4: partial products of h*h and a*|c|
    logic [AW-1:0] w_ha, w_ca;
    assign w_ha = r3_h[HW-1] ? AW'(-r3_h) : AW'(r3_h);
    assign w_ca = r3_c[HW-1] ? AW'(-r3_c) : AW'(r3_c);

    logic                 r_v4;
    t_geo                 r4_g;
    logic [AW-1:0]        r4_a;
    logic signed [HW-1:0] r4_h;
    logic                 r4_cneg;
    logic [2*HB-1:0]      r4_hll, r4_hlh, r4_hhh, r4_all, r4_alh, r4_ahl, r4_ahh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (w_en) begin
            r_v4 <= r_v3;
        end
        if (w_en) begin
            r4_g    <= r3_g;
            r4_a    <= r3_a;
            r4_h    <= r3_h;
            r4_cneg <= r3_c[HW-1];
            r4_hll  <= (2*HB)'(w_ha[HB-1:0])  * (2*HB)'(w_ha[HB-1:0]);
            r4_hlh  <= (2*HB)'(w_ha[HB-1:0])  * (2*HB)'(w_ha[AW-1:HB]);
            r4_hhh  <= (2*HB)'(w_ha[AW-1:HB]) * (2*HB)'(w_ha[AW-1:HB]);
            r4_all  <= (2*HB)'(r3_a[HB-1:0])  * (2*HB)'(w_ca[HB-1:0]);
            r4_alh  <= (2*HB)'(r3_a[HB-1:0])  * (2*HB)'(w_ca[AW-1:HB]);
            r4_ahl  <= (2*HB)'(r3_a[AW-1:HB]) * (2*HB)'(w_ca[HB-1:0]);
            r4_ahh  <= (2*HB)'(r3_a[AW-1:HB]) * (2*HB)'(w_ca[AW-1:HB]);
        end
    end

    // stage 5: combine
    logic                 r_v5;
    t_geo                 r5_g;
    logic [AW-1:0]        r5_a;
    logic signed [HW-1:0] r5_h;
    logic                 r5_cneg;
    logic [MW-1:0]        r5_hsq, r5_ac;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else if (w_en) begin
            r_v5 <= r_v4;
        end
        if (w_en) begin
            r5_g    <= r4_g;
            r5_a    <= r4_a;
            r5_h    <= r4_h;
            r5_cneg <= r4_cneg;
            r5_hsq  <= MW'(r4_hll) + (MW'(r4_hlh) << (HB+1)) + (MW'(r4_hhh) << (2*HB));
            r5_ac   <= MW'(r4_all) + ((MW'(r4_alh) + MW'(r4_ahl)) << HB)
                       + (MW'(r4_ahh) << (2*HB));
        end
    end

    // stage 6: discriminant
    logic                 r_v6;
    t_geo                 r6_g;
    logic [AW-1:0]        r6_a;
    logic signed [HW-1:0] r6_h;
    logic                 r6_nr;
    logic [MW-1:0]        r6_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v6 <= 1'b0;
        end else if (w_en) begin
            r_v6 <= r_v5;
        end
        if (w_en) begin
            r6_g  <= r5_g;
            r6_a  <= r5_a;
            r6_h  <= r5_h;
            r6_nr <= !r5_cneg && (r5_ac > r5_hsq);
            r6_q  <= r5_cneg ? r5_hsq + r5_ac : r5_hsq - r5_ac;
        end
    end

    // square root, one root bit per stage
    logic                 r_sq_v    [SQ];
    t_geo                 r_sq_g    [SQ];
    logic [AW-1:0]        r_sq_a    [SQ];
    logic signed [HW-1:0] r_sq_h    [SQ];
    logic                 r_sq_nr   [SQ];
    logic [RW-1:0]        r_sq_rem  [SQ];
    logic [SW-1:0]        r_sq_root [SQ];
    logic [MW-1:0]        r_sq_rad  [SQ];

    for (genvar k = 0; k < SQ; k++) begin : g_sq
        logic                 w_v, w_nr;
        t_geo                 w_g;
        logic [AW-1:0]        w_a;
        logic signed [HW-1:0] w_h;
        logic [RW-1:0]        w_rem, w_rem4, w_trial;
        logic [SW-1:0]        w_root;
        logic [MW-1:0]        w_rad;
        logic                 w_ge;

        if (k == 0) begin : g_first
            assign w_v    = r_v6;
            assign w_g    = r6_g;
            assign w_a    = r6_a;
            assign w_h    = r6_h;
            assign w_nr   = r6_nr;
            assign w_rem  = '0;
            assign w_root = '0;
            assign w_rad  = r6_q;
        end else begin : g_next
            assign w_v    = r_sq_v[k-1];
            assign w_g    = r_sq_g[k-1];
            assign w_a    = r_sq_a[k-1];
            assign w_h    = r_sq_h[k-1];
            assign w_nr   = r_sq_nr[k-1];
            assign w_rem  = r_sq_rem[k-1];
            assign w_root = r_sq_root[k-1];
            assign w_rad  = r_sq_rad[k-1];
        end

        assign w_rem4  = {w_rem[RW-3:0], w_rad[MW-1:MW-2]};
        assign w_trial = {w_root, 2'b01};
        assign w_ge    = w_rem4 >= w_trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_v[k] <= 1'b0;
            end else if (w_en) begin
                r_sq_v[k] <= w_v;
            end
            if (w_en) begin
                r_sq_g[k]    <= w_g;
                r_sq_a[k]    <= w_a;
                r_sq_h[k]    <= w_h;
                r_sq_nr[k]   <= w_nr;
                r_sq_rem[k]  <= w_ge ? w_rem4 - w_trial : w_rem4;
                r_sq_root[k] <= {w_root[SW-2:0], w_ge};
                r_sq_rad[k]  <= {w_rad[MW-3:0], 2'b00};
            end
        end
    end

    // pick the root nearer the start point
    logic [SW-1:0]        w_s;
    logic signed [NW-1:0] w_hn;
    assign w_s  = r_sq_root[SQ-1];
    assign w_hn = -NW'(r_sq_h[SQ-1]);

    logic                 r_vn;
    t_geo                 rn_g;
    logic [AW-1:0]        rn_a;
    logic                 rn_nr;
    logic signed [NW-1:0] rn_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vn <= 1'b0;
        end else if (w_en) begin
            r_vn <= r_sq_v[SQ-1];
        end
        if (w_en) begin
            rn_g  <= r_sq_g[SQ-1];
            rn_a  <= r_sq_a[SQ-1];
            rn_nr <= r_sq_nr[SQ-1];
            rn_n  <= (r_sq_h[SQ-1] > 0 && w_s != '0) ? w_hn + $signed(NW'(w_s))
                                                      : w_hn - $signed(NW'(w_s));
        end
    end

    // d * n partial products
    logic [NMW-1:0] w_nm;
    logic [DW-1:0]  w_dxm, w_dym;
    assign w_nm  = rn_n[NW-1] ? NMW'(-rn_n) : NMW'(rn_n);
    assign w_dxm = rn_g.dx[DW-1] ? -rn_g.dx : rn_g.dx;
    assign w_dym = rn_g.dy[DW-1] ? -rn_g.dy : rn_g.dy;

    logic               r_vm1;
    t_tail              rm1_t;
    logic [DW+NLB-1:0]  rm1_xl, rm1_yl;
    logic [DW+NHB-1:0]  rm1_xh, rm1_yh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vm1 <= 1'b0;
        end else if (w_en) begin
            r_vm1 <= r_vn;
        end
        if (w_en) begin
            rm1_t.g   <= rn_g;
            rm1_t.a   <= rn_a;
            rm1_t.z   <= rn_g.deg || rn_nr;
            rm1_t.hit <= !rn_g.deg && !rn_nr && (NMW'(rn_a) >= w_nm);
            rm1_t.sgx <= rn_g.dx[DW-1] ^ rn_n[NW-1];
            rm1_t.sgy <= rn_g.dy[DW-1] ^ rn_n[NW-1];
            rm1_xl    <= (DW+NLB)'(w_dxm) * (DW+NLB)'(w_nm[NLB-1:0]);
            rm1_xh    <= (DW+NHB)'(w_dxm) * (DW+NHB)'(w_nm[NMW-1:NLB]);
            rm1_yl    <= (DW+NLB)'(w_dym) * (DW+NLB)'(w_nm[NLB-1:0]);
            rm1_yh    <= (DW+NHB)'(w_dym) * (DW+NHB)'(w_nm[NMW-1:NLB]);
        end
    end

    // rounded numerators
    logic            r_vm2;
    t_tail           rm2_t;
    logic [NUMW-1:0] rm2_nx, rm2_ny;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vm2 <= 1'b0;
        end else if (w_en) begin
            r_vm2 <= r_vm1;
        end
        if (w_en) begin
            rm2_t  <= rm1_t;
            rm2_nx <= NUMW'(rm1_xl) + (NUMW'(rm1_xh) << NLB) + NUMW'(rm1_t.a >> 1);
            rm2_ny <= NUMW'(rm1_yl) + (NUMW'(rm1_yh) << NLB) + NUMW'(rm1_t.a >> 1);
        end
    end

    // restoring divider, one quotient bit per stage
    logic            r_dv_v  [NUMW];
    t_tail           r_dv_t  [NUMW];
    logic [AW-1:0]   r_dv_rx [NUMW];
    logic [AW-1:0]   r_dv_ry [NUMW];
    logic [NUMW-1:0] r_dv_nx [NUMW];
    logic [NUMW-1:0] r_dv_ny [NUMW];

    for (genvar j = 0; j < NUMW; j++) begin : g_dv
        logic            w_v, w_gx, w_gy;
        t_tail           w_t;
        logic [AW-1:0]   w_rx, w_ry;
        logic [NUMW-1:0] w_nx, w_ny;
        logic [AW:0]     w_x2, w_y2;

        if (j == 0) begin : g_first
            assign w_v  = r_vm2;
            assign w_t  = rm2_t;
            assign w_rx = '0;
            assign w_ry = '0;
            assign w_nx = rm2_nx;
            assign w_ny = rm2_ny;
        end else begin : g_next
            assign w_v  = r_dv_v[j-1];
            assign w_t  = r_dv_t[j-1];
            assign w_rx = r_dv_rx[j-1];
            assign w_ry = r_dv_ry[j-1];
            assign w_nx = r_dv_nx[j-1];
            assign w_ny = r_dv_ny[j-1];
        end

        assign w_x2 = {w_rx, w_nx[NUMW-1]};
        assign w_y2 = {w_ry, w_ny[NUMW-1]};
        assign w_gx = w_x2 >= (AW+1)'(w_t.a);
        assign w_gy = w_y2 >= (AW+1)'(w_t.a);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[j] <= 1'b0;
            end else if (w_en) begin
                r_dv_v[j] <= w_v;
            end
            if (w_en) begin
                r_dv_t[j]  <= w_t;
                r_dv_rx[j] <= AW'(w_gx ? w_x2 - (AW+1)'(w_t.a) : w_x2);
                r_dv_ry[j] <= AW'(w_gy ? w_y2 - (AW+1)'(w_t.a) : w_y2);
                r_dv_nx[j] <= {w_nx[NUMW-2:0], w_gx};
                r_dv_ny[j] <= {w_ny[NUMW-2:0], w_gy};
            end
        end
    end

    // offset from start point, saturate; zero for a degenerate segment or no intersection
    t_tail                  w_ft;
    logic signed [SUMW-1:0] w_qx, w_qy, w_sumx, w_sumy;
    logic signed [W-1:0]    w_ox, w_oy;

    assign w_ft   = r_dv_t[NUMW-1];
    assign w_qx   = $signed(SUMW'(r_dv_nx[NUMW-1]));
    assign w_qy   = $signed(SUMW'(r_dv_ny[NUMW-1]));
    assign w_sumx = SUMW'(w_ft.g.sx) + (w_ft.sgx ? -w_qx : w_qx);
    assign w_sumy = SUMW'(w_ft.g.sy) + (w_ft.sgy ? -w_qy : w_qy);

    always_comb begin
        if (w_ft.z) begin
            w_ox = '0;
        end else if (w_sumx > SUMW'(C_MAX)) begin
            w_ox = C_MAX;
        end else if (w_sumx < SUMW'(C_MIN)) begin
            w_ox = C_MIN;
        end else begin
            w_ox = W'(w_sumx);
        end
        if (w_ft.z) begin
            w_oy = '0;
        end else if (w_sumy > SUMW'(C_MAX)) begin
            w_oy = C_MAX;
        end else if (w_sumy < SUMW'(C_MIN)) begin
            w_oy = C_MIN;
        end else begin
            w_oy = W'(w_sumy);
        end
    end

    logic         r_out_v, r_out_hit;
    logic [W-1:0] r_out_x, r_out_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r_out_v <= r_dv_v[NUMW-1];
        end
        if (w_en) begin
            r_out_hit <= w_ft.hit;
            r_out_x   <= w_ox;
            r_out_y   <= w_oy;
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = OUT_TW'({r_out_y, r_out_x, r_out_hit});
endmodule
`default_nettype wire

// ----- sim/segment_circle_intersect_tb.sv -----
`timescale 1ns / 1ps
`default_nettype none
module segment_circle_intersect_tb;
    localparam int CW = sci_pkg::SCI_COORD_WIDTH;
    localparam int IN_W = ((7 * CW - 1 + 7) / 8) * 8;
    localparam int OUT_W = ((2 * CW + 1 + 7) / 8) * 8;
    localparam int LATENCY = 5 * CW + 17;
    localparam int N_RANDOM = 1600;

    typedef struct packed {
        logic [CW-2:0] r;
        logic signed [CW-1:0] cy, cx, ey, ex, sy, sx;
    } t_query;

    typedef struct packed {
        logic signed [CW-1:0] iy, ix;
        logic hit;
    } t_answer;

    function automatic logic [127:0] isqrt128(input logic [127:0] v);
        logic [127:0] res, cand;
        res = '0;
        for (int b = 63; b >= 0; b--) begin
            cand = res | (128'd1 << b);
            if (cand * cand <= v) res = cand;
        end
        return res;
    endfunction

    function automatic logic signed [CW-1:0] clamp_coord(input longint v);
        longint hi, lo;
        hi = (64'sd1 <<< (CW - 1)) - 1;
        lo = -(64'sd1 <<< (CW - 1));
        if (v > hi) v = hi;
        if (v < lo) v = lo;
        return v[CW-1:0];
    endfunction

    function automatic longint div_round(input longint num, input longint den);
        longint q, m;
        m = (num < 0) ? -num : num;
        q = (m + den / 2) / den;
        return (num < 0) ? -q : q;
    endfunction

    function automatic t_answer intersect_predict(input t_query q);
        t_answer o;
        longint sx, sy, dx, dy, fx, fy, rr, a, h, c, s, n0, n1, n, an;
        logic signed [127:0] qq;
        o = '0;
        sx = q.sx; sy = q.sy;
        dx = longint'(q.ex) - sx; dy = longint'(q.ey) - sy;
        fx = sx - q.cx; fy = sy - q.cy;
        rr = q.r;
        a = dx * dx + dy * dy;
        if (a == 0) return o;
        h = dx * fx + dy * fy;
        c = fx * fx + fy * fy - rr * rr;
        qq = 128'(h) * 128'(h) - 128'(a) * 128'(c);
        if (qq < 0) return o;
        s = longint'(isqrt128(qq));
        n0 = -h + s;
        n1 = -h - s;
        n = (((n0 < 0) ? -n0 : n0) < ((n1 < 0) ? -n1 : n1)) ? n0 : n1;
        an = (n < 0) ? -n : n;
        o.hit = (an <= a);
        o.ix = clamp_coord(sx + div_round(dx * n, a));
        o.iy = clamp_coord(sy + div_round(dy * n, a));
        return o;
    endfunction

    class intersect_scoreboard;
        t_answer pending[$];
        int errors;
        int hits;
        int checked;

        function void note_request(t_query q);
            pending.push_back(intersect_predict(q));
        endfunction

        function void check_answer(t_answer got);
            t_answer want;
            if (pending.size() == 0) begin
                $display("%0t unexpected result %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            checked++;
            if (want.hit) hits++;
            if (got.hit !== want.hit) begin
                $display("%0t hit exp %0d got %0d", $time, want.hit, got.hit);
                errors++;
            end
            if (got.ix !== want.ix) begin
                $display("%0t intersect_x exp %0d got %0d", $time, want.ix, got.ix);
                errors++;
            end
            if (got.iy !== want.iy) begin
                $display("%0t intersect_y exp %0d got %0d", $time, want.iy, got.iy);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_W-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;

    intersect_scoreboard sb = new();
    bit hold_off_req = 0;
    bit hold_off_done = 0;
    int burst_left = 0;

    segment_circle_intersect uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_request(t_query'(s_axis_tdata[7*CW-2:0]));
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_answer(t_answer'(m_axis_tdata[2*CW:0]));
    end

    // stall on a cycling pattern; one long hold-off on request
    initial begin
        int phase;
        phase = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off_req && !hold_off_done) begin
                m_axis_tready <= 1'b0;
                repeat (3 * LATENCY) @(negedge i_clk);
                hold_off_done = 1;
            end
            phase = (phase + 1) % 64;
            if (phase < 20) m_axis_tready <= 1'b1;
            else if (phase < 40) m_axis_tready <= (($urandom % 4) != 0);
            else m_axis_tready <= 1'($urandom_range(0, 1));
        end
    end

    function automatic logic signed [CW-1:0] rand_coord(input int spread);
        int v;
        case ($urandom_range(0, 7))
            0: return {1'b0, {(CW - 1){1'b1}}};
            1: return {1'b1, {(CW - 1){1'b0}}};
            2, 3: return CW'($urandom);
            default: begin
                v = int'($urandom_range(0, 2 * spread)) - spread;
                return v[CW-1:0];
            end
        endcase
    endfunction

    function automatic t_query random_query();
        t_query q;
        int spread;
        logic signed [CW-1:0] base_x, base_y;
        spread = ($urandom_range(0, 3) == 0) ? 30000 : 2000;
        base_x = rand_coord(spread);
        base_y = rand_coord(spread);
        q.cx = base_x;
        q.cy = base_y;
        q.sx = base_x + rand_coord(spread);
        q.sy = base_y + rand_coord(spread);
        if ($urandom_range(0, 19) == 0) begin
            q.ex = q.sx;
            q.ey = q.sy;
        end else begin
            q.ex = base_x + rand_coord(spread);
            q.ey = base_y + rand_coord(spread);
        end
        q.r = ($urandom_range(0, 5) == 0) ? (CW-1)'($urandom)
                                          : (CW-1)'($urandom_range(0, spread));
        return q;
    endfunction

    function automatic t_query make_query(input logic signed [CW-1:0] sx, sy, ex, ey, cx, cy,
                                          input logic [CW-2:0] r);
        t_query q;
        q.sx = sx;
        q.sy = sy;
        q.ex = ex;
        q.ey = ey;
        q.cx = cx;
        q.cy = cy;
        q.r = r;
        return q;
    endfunction

    task automatic send_request(input t_query q);
        s_axis_tdata <= IN_W'(q);
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic pace_sender();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
            return;
        end
        gap = int'($urandom_range(0, 6));
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        burst_left = int'($urandom_range(0, 30));
    endtask

    task automatic drain_results();
        if (sb.pending.size() != 0) begin
            s_axis_tvalid <= 1'b0;
            while (sb.pending.size() != 0) @(negedge i_clk);
        end
    endtask

    localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW - 1){1'b1}}};
    localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW - 1){1'b0}}};
    localparam logic [CW-2:0] RMAX = '1;

    initial begin
        t_query directed[$];
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        directed.push_back(make_query(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 15'd100));
        directed.push_back(make_query(16'sd100, 16'sd5, 16'sd100, 16'sd5, 16'sd0, 16'sd0,
                                      15'd200));
        directed.push_back(make_query(-16'sd500, 16'sd0, 16'sd500, 16'sd0, 16'sd0, 16'sd0,
                                      15'd160));
        directed.push_back(make_query(-16'sd500, 16'sd300, 16'sd500, 16'sd300, 16'sd0, 16'sd0,
                                      15'd100));
        directed.push_back(make_query(-16'sd100, 16'sd160, 16'sd100, 16'sd160, 16'sd0, 16'sd0,
                                      15'd160));
        directed.push_back(make_query(16'sd0, 16'sd0, 16'sd10, 16'sd0, 16'sd0, 16'sd0, 15'd50));
        directed.push_back(make_query(16'sd400, 16'sd0, 16'sd800, 16'sd0, 16'sd0, 16'sd0,
                                      15'd100));
        directed.push_back(make_query(-16'sd10, 16'sd0, 16'sd10, 16'sd0, 16'sd0, 16'sd0, 15'd0));
        directed.push_back(make_query(CMIN, CMIN, CMAX, CMAX, CMAX, CMIN, RMAX));
        directed.push_back(make_query(CMAX, CMAX, CMIN, CMIN, CMIN, CMAX, RMAX));
        directed.push_back(make_query(CMAX, CMIN, CMIN, CMAX, 16'sd0, 16'sd0, RMAX));
        directed.push_back(make_query(CMIN, 16'sd0, CMAX, 16'sd0, CMAX, CMAX, 15'd1));
        directed.push_back(make_query(16'sd0, 16'sd0, 16'sd1, 16'sd1, CMIN, CMIN, RMAX));
        directed.push_back(make_query(CMAX, CMAX, CMAX, CMAX, CMIN, CMIN, RMAX));
        directed.push_back(make_query(16'sd3, -16'sd7, 16'sd5, -16'sd2, 16'sd4, -16'sd4,
                                      15'd3));
        directed.push_back(make_query(-16'sd1, -16'sd1, -16'sd2, -16'sd2, 16'sd0, 16'sd0,
                                      15'd1));
        foreach (directed[i]) send_request(directed[i]);
        drain_results();

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == N_RANDOM / 3) hold_off_req = 1;
            if (i == 2 * N_RANDOM / 3) drain_results();
            if (i > N_RANDOM / 2 || i < N_RANDOM / 4) pace_sender();
            send_request(random_query());
        end
        drain_results();
        repeat (LATENCY + 20) @(negedge i_clk);

        $display("checked %0d results across %0d directed and %0d random queries, %0d hits",
                 sb.checked, directed.size(), N_RANDOM, sb.hits);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("[segment_circle_intersect] OK");
        end else begin
            $display("[segment_circle_intersect] ERROR");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("[segment_circle_intersect] ERROR");
        $finish;
    end
endmodule
`default_nettype wire
